// ===== src/prsp_pkg.sv =====
// ----------------------------------------------------------------------------
// prsp_pkg
// Types, codes and helper functions shared by the resource stream parser
// and its port checker.
// ----------------------------------------------------------------------------
package prsp_pkg;

  // Parse phases
  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_TAG    = 3'd1,
    PH_LENLO  = 3'd2,
    PH_LENHI  = 3'd3,
    PH_BODY   = 3'd4,
    PH_DONE   = 3'd5
  } parse_phase_e;

  // Role of each word on the result stream
  localparam logic [2:0] ROLE_HEADER  = 3'd0;
  localparam logic [2:0] ROLE_VERDICT = 3'd1;
  localparam logic [2:0] ROLE_TAG     = 3'd2;
  localparam logic [2:0] ROLE_LENGTH  = 3'd3;
  localparam logic [2:0] ROLE_ACCEPT  = 3'd4;
  localparam logic [2:0] ROLE_SKIP    = 3'd5;
  localparam logic [2:0] ROLE_IGNORED = 3'd6;

  // Parse status codes
  localparam logic [1:0] STATUS_RUNNING = 2'd0;
  localparam logic [1:0] STATUS_END     = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  // Resource item types (small types 0..15, large types as full tag byte)
  localparam logic [7:0] TYPE_VERSION   = 8'h01;
  localparam logic [7:0] TYPE_LDEV      = 8'h02;
  localparam logic [7:0] TYPE_COMPAT    = 8'h03;
  localparam logic [7:0] TYPE_IRQ       = 8'h04;
  localparam logic [7:0] TYPE_DMA       = 8'h05;
  localparam logic [7:0] TYPE_START_DEP = 8'h06;
  localparam logic [7:0] TYPE_END_DEP   = 8'h07;
  localparam logic [7:0] TYPE_IO_PORT   = 8'h08;
  localparam logic [7:0] TYPE_FIXED_IO  = 8'h09;
  localparam logic [7:0] TYPE_END       = 8'h0f;
  localparam logic [7:0] TYPE_MEM       = 8'h81;
  localparam logic [7:0] TYPE_ANSI      = 8'h82;
  localparam logic [7:0] TYPE_MEM32     = 8'h85;
  localparam logic [7:0] TYPE_FMEM32    = 8'h86;
  localparam logic [7:0] TYPE_BAD_LARGE = 8'hff;

  localparam logic [15:0] LEN_BAD_LARGE = 16'hffff;
  localparam logic [15:0] ANSI_LIMIT    = 16'd1023;
  localparam logic [7:0]  LFSR_SEED     = 8'h6a;
  localparam logic [3:0]  HEADER_BYTES  = 4'd8;

  // Outcome of the size check made once type and length are known
  typedef struct packed {
    logic       accept;
    logic       device;
    logic       skip;
    logic [2:0] compat;
    logic [8:0] prio;
    logic [7:0] devices;
    logic [1:0] status;
  } item_t;

  // Serial identifier checksum: eight LFSR steps, data LSB first
  function automatic logic [7:0] lfsr_byte(input logic [7:0] seed, input logic [7:0] data);
    logic [7:0] s;
    logic       fb;
    s = seed;
    for (int j = 0; j < 8; j++) begin
      fb = s[0] ^ s[1] ^ data[j];
      s  = {fb, s[7:1]};
    end
    return s;
  endfunction

endpackage

// ===== src/pnp_resource_stream_parser.sv =====
// ----------------------------------------------------------------------------
// pnp_resource_stream_parser
// Parses one plug-and-play card's serial identifier and resource data.
// ----------------------------------------------------------------------------
// One input word per byte of the card stream, one result word per input word.
// Every word is decoded combinationally from the kept parse state and lands
// in the output register, so a new word is taken on every clock while the
// output side keeps up; the result is valid in the cycle after the accept.
// tuser on the input flags the first header byte of a new card, which clears
// all parse state before that byte is used. The first eight bytes feed the
// checksum LFSR, the ninth gives the header verdict, then resource tags are
// decoded until an end tag, an invalid tag or an invalid header, after which
// bytes are marked ignored until the next new card.
module pnp_resource_stream_parser #(
  parameter int unsigned MAX_COMPAT = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tuser,  // [0] new_card
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] header_ok, [8:1] id_checksum, [16:9] item_type, [32:17] item_length,
  // [48:33] body_index, [49] inside_device, [57:50] devices_seen,
  // [60:58] compat_seen, [69:61] dep_priority, [77:70] resource_sum,
  // [79:78] parse_status
  output logic [79:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser   // [2:0] byte_role
);
  import prsp_pkg::*;

  localparam logic [2:0] CompatMax = 3'(MAX_COMPAT);

  // Parse state
  parse_phase_e phase_q, phase_d;
  logic [3:0]  hcount_q, hcount_d;
  logic [7:0]  lfsr_q, lfsr_d;
  logic        hdr_valid_q, hdr_valid_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  len_lo_q, len_lo_d;
  logic [15:0] len_q, len_d;
  logic [15:0] pos_q, pos_d;
  logic        dev_q, dev_d;
  logic        skip_q, skip_d;
  logic        item_acc_q, item_acc_d;
  logic [7:0]  devs_q, devs_d;
  logic [2:0]  compat_q, compat_d;
  logic [8:0]  prio_q, prio_d;
  logic [7:0]  sum_q, sum_d;
  logic [1:0]  status_q, status_d;

  // Output register
  logic        m_valid_q;
  logic [79:0] m_data_q;
  logic [2:0]  m_user_q;

  logic        in_fire;
  logic [7:0]  b;
  logic        nc;

  // State as seen by this word: a new card starts from reset values
  parse_phase_e cur_phase;
  logic [3:0]  cur_hcount;
  logic [7:0]  cur_lfsr;
  logic [7:0]  cur_type;
  logic [7:0]  cur_len_lo;
  logic [15:0] cur_len;
  logic [15:0] cur_pos;
  logic        cur_dev;
  logic        cur_skip;
  logic        cur_item_acc;
  logic [7:0]  cur_devs;
  logic [2:0]  cur_compat;
  logic [8:0]  cur_prio;
  logic [7:0]  cur_sum;
  logic [1:0]  cur_status;

  logic [7:0]  it_type;
  logic [15:0] it_len;
  logic        len_ldev_ok;
  logic [7:0]  devs_inc;
  item_t       item;
  parse_phase_e item_phase;
  logic        body_acc;
  logic        body_last;
  logic [2:0]  role;
  logic [15:0] index;
  logic [7:0]  sum_add;

  assign b             = s_axis_tdata;
  assign nc            = s_axis_tuser;
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign cur_phase    = nc ? PH_HEADER : phase_q;
  assign cur_hcount   = nc ? 4'd0 : hcount_q;
  assign cur_lfsr     = nc ? LFSR_SEED : lfsr_q;
  assign cur_type     = nc ? 8'd0 : type_q;
  assign cur_len_lo   = nc ? 8'd0 : len_lo_q;
  assign cur_len      = nc ? 16'd0 : len_q;
  assign cur_pos      = nc ? 16'd0 : pos_q;
  assign cur_dev      = nc ? 1'b0 : dev_q;
  assign cur_skip     = nc ? 1'b0 : skip_q;
  assign cur_item_acc = nc ? 1'b0 : item_acc_q;
  assign cur_devs     = nc ? 8'd0 : devs_q;
  assign cur_compat   = nc ? 3'd0 : compat_q;
  assign cur_prio     = nc ? 9'd0 : prio_q;
  assign cur_sum      = nc ? 8'd0 : sum_q;
  assign cur_status   = nc ? STATUS_RUNNING : status_q;

  // Item type and length: small tag in this byte, or large tag completed now
  assign it_type     = (cur_phase == PH_LENHI) ? cur_type : {4'd0, b[6:3]};
  assign it_len      = (cur_phase == PH_LENHI) ? {b, cur_len_lo} : {13'd0, b[2:0]};
  assign len_ldev_ok = (it_len == 16'd5) || (it_len == 16'd6);
  assign devs_inc    = (cur_devs == 8'hff) ? cur_devs : cur_devs + 8'd1;
  assign sum_add     = cur_sum + b;

  // Size check and context updates for a new item
  always_comb begin
    item.accept  = 1'b0;
    item.device  = cur_dev;
    item.skip    = cur_skip;
    item.compat  = cur_compat;
    item.prio    = cur_prio;
    item.devices = cur_devs;
    item.status  = cur_status;
    if (it_type == TYPE_END) begin
      item.status = STATUS_END;
    end else if (!cur_dev) begin
      unique case (it_type)
        TYPE_VERSION: item.accept = (it_len == 16'd2);
        TYPE_LDEV: begin
          if (len_ldev_ok) begin
            item.accept  = 1'b1;
            item.device  = 1'b1;
            item.devices = devs_inc;
            item.compat  = 3'd0;
            item.prio    = 9'd0;
            item.skip    = 1'b0;
          end
        end
        TYPE_ANSI: item.accept = 1'b1;
        default: ;
      endcase
    end else if (!cur_skip || it_type == TYPE_LDEV) begin
      unique case (it_type)
        TYPE_LDEV: begin
          item.prio   = 9'd0;
          item.compat = 3'd0;
          if (len_ldev_ok) begin
            item.accept  = 1'b1;
            item.devices = devs_inc;
            item.skip    = 1'b0;
          end else begin
            item.skip = 1'b1;
          end
        end
        TYPE_COMPAT: begin
          if (it_len == 16'd4 && cur_compat < CompatMax) begin
            item.accept = 1'b1;
            item.compat = cur_compat + 3'd1;
          end
        end
        TYPE_IRQ:       item.accept = (it_len == 16'd2) || (it_len == 16'd3);
        TYPE_DMA:       item.accept = (it_len == 16'd2);
        TYPE_START_DEP: item.accept = (it_len <= 16'd1);
        TYPE_END_DEP: begin
          if (it_len == 16'd0) begin
            item.accept = 1'b1;
            item.prio   = 9'd0;
          end
        end
        TYPE_IO_PORT:  item.accept = (it_len == 16'd7);
        TYPE_FIXED_IO: item.accept = (it_len == 16'd3);
        TYPE_MEM:      item.accept = (it_len == 16'd9);
        TYPE_ANSI:     item.accept = 1'b1;
        TYPE_MEM32:    item.accept = (it_len == 16'd17);
        TYPE_FMEM32:   item.accept = (it_len == 16'd9);
        default: ;
      endcase
    end
  end

  // Phase after an item header: body if any payload, else next tag or stop
  always_comb begin
    if (it_len != 16'd0) begin
      item_phase = PH_BODY;
    end else if (item.status != STATUS_RUNNING) begin
      item_phase = PH_DONE;
    end else begin
      item_phase = PH_TAG;
    end
  end

  // Payload byte classification; long ANSI strings are clipped
  assign body_acc  = cur_item_acc && (cur_type != TYPE_ANSI || cur_pos < ANSI_LIMIT);
  assign body_last = ({1'b0, cur_pos} + 17'd1) >= {1'b0, cur_len};

  // Next state
  always_comb begin
    phase_d     = cur_phase;
    hcount_d    = cur_hcount;
    lfsr_d      = cur_lfsr;
    hdr_valid_d = nc ? 1'b0 : hdr_valid_q;
    type_d      = cur_type;
    len_lo_d    = cur_len_lo;
    len_d       = cur_len;
    pos_d       = cur_pos;
    dev_d       = cur_dev;
    skip_d      = cur_skip;
    item_acc_d  = cur_item_acc;
    devs_d      = cur_devs;
    compat_d    = cur_compat;
    prio_d      = cur_prio;
    sum_d       = cur_sum;
    status_d    = cur_status;
    unique case (cur_phase)
      PH_HEADER: begin
        if (cur_hcount < HEADER_BYTES) begin
          lfsr_d   = lfsr_byte(cur_lfsr, b);
          hcount_d = cur_hcount + 4'd1;
        end else begin
          hdr_valid_d = (b == 8'd0) || (cur_lfsr != 8'd0 && cur_lfsr == b);
          phase_d     = hdr_valid_d ? PH_TAG : PH_DONE;
        end
      end
      PH_TAG: begin
        sum_d = sum_add;
        if (b == 8'd0) begin
          type_d   = 8'd0;
          len_d    = 16'd0;
          status_d = STATUS_INVALID;
          phase_d  = PH_DONE;
        end else if (b[7]) begin
          type_d  = b;
          len_d   = 16'd0;
          phase_d = PH_LENLO;
        end else begin
          type_d     = it_type;
          len_d      = it_len;
          item_acc_d = item.accept;
          dev_d      = item.device;
          skip_d     = item.skip;
          compat_d   = item.compat;
          prio_d     = item.prio;
          devs_d     = item.devices;
          status_d   = item.status;
          pos_d      = 16'd0;
          phase_d    = item_phase;
        end
      end
      PH_LENLO: begin
        sum_d    = sum_add;
        len_lo_d = b;
        len_d    = {8'd0, b};
        phase_d  = PH_LENHI;
      end
      PH_LENHI: begin
        sum_d = sum_add;
        len_d = it_len;
        if (cur_type == TYPE_BAD_LARGE && it_len == LEN_BAD_LARGE) begin
          status_d = STATUS_INVALID;
          phase_d  = PH_DONE;
        end else begin
          item_acc_d = item.accept;
          dev_d      = item.device;
          skip_d     = item.skip;
          compat_d   = item.compat;
          prio_d     = item.prio;
          devs_d     = item.devices;
          status_d   = item.status;
          pos_d      = 16'd0;
          phase_d    = item_phase;
        end
      end
      PH_BODY: begin
        sum_d = sum_add;
        if (body_acc && cur_dev && cur_type == TYPE_START_DEP && cur_pos == 16'd0) begin
          prio_d = {1'b1, b};
        end
        if (body_last) begin
          pos_d   = 16'd0;
          phase_d = (cur_status != STATUS_RUNNING) ? PH_DONE : PH_TAG;
        end else begin
          pos_d = cur_pos + 16'd1;
        end
      end
      default: ;
    endcase
  end

  // Byte role and payload index
  always_comb begin
    role  = ROLE_IGNORED;
    index = 16'd0;
    unique case (cur_phase)
      PH_HEADER: role = (cur_hcount < HEADER_BYTES) ? ROLE_HEADER : ROLE_VERDICT;
      PH_TAG:    role = ROLE_TAG;
      PH_LENLO,
      PH_LENHI:  role = ROLE_LENGTH;
      PH_BODY: begin
        role  = body_acc ? ROLE_ACCEPT : ROLE_SKIP;
        index = cur_pos;
      end
      default:   role = ROLE_IGNORED;
    endcase
  end

  // State registers, updated on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      hcount_q    <= 4'd0;
      lfsr_q      <= LFSR_SEED;
      hdr_valid_q <= 1'b0;
      type_q      <= 8'd0;
      len_lo_q    <= 8'd0;
      len_q       <= 16'd0;
      pos_q       <= 16'd0;
      dev_q       <= 1'b0;
      skip_q      <= 1'b0;
      item_acc_q  <= 1'b0;
      devs_q      <= 8'd0;
      compat_q    <= 3'd0;
      prio_q      <= 9'd0;
      sum_q       <= 8'd0;
      status_q    <= STATUS_RUNNING;
    end else if (in_fire) begin
      phase_q     <= phase_d;
      hcount_q    <= hcount_d;
      lfsr_q      <= lfsr_d;
      hdr_valid_q <= hdr_valid_d;
      type_q      <= type_d;
      len_lo_q    <= len_lo_d;
      len_q       <= len_d;
      pos_q       <= pos_d;
      dev_q       <= dev_d;
      skip_q      <= skip_d;
      item_acc_q  <= item_acc_d;
      devs_q      <= devs_d;
      compat_q    <= compat_d;
      prio_q      <= prio_d;
      sum_q       <= sum_d;
      status_q    <= status_d;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (in_fire) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      m_user_q <= role;
      m_data_q <= {status_d, sum_d, prio_d, compat_d, devs_d, dev_d,
                   index, len_d, type_d, lfsr_d, hdr_valid_d};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

// ===== src/prsp_checker.sv =====
// ----------------------------------------------------------------------------
// prsp_checker
// Port-level checks for the resource stream parser, bound to the top level.
// ----------------------------------------------------------------------------
module prsp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);
  import prsp_pkg::*;

  // Stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result word changed");

  // Input is never held off while the output register is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // Every accepted word gives a result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted word produced no result");

  // A new card starts with a header byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> m_axis_tuser == ROLE_HEADER)
    else $error("new card did not start in header");

  // Payload index is zero outside body bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ROLE_ACCEPT && m_axis_tuser != ROLE_SKIP
      |-> m_axis_tdata[48:33] == 16'd0)
    else $error("body index nonzero on a non-body word");

endmodule

bind pnp_resource_stream_parser prsp_checker u_prsp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
